### hw/rtl/srfh_pkg.sv
// Shared types, constants and the edge classification function.
`timescale 1ns / 1ps
package srfh_pkg;

  localparam int DIV_STEPS = 32;
  localparam int EDGE_COUNT = 4;

  localparam logic [2:0] SRC_START = 3'd0;
  localparam logic [2:0] SRC_END   = 3'd1;
  localparam logic [2:0] SRC_EDGE0 = 3'd2;

  typedef struct packed {
    logic               ok;
    logic        [31:0] a;
    logic        [31:0] d;
    logic        [31:0] m;
    logic               neg;
    logic signed [31:0] sb;
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    logic signed [33:0] level;
  } edge_t;

  typedef struct packed {
    logic               start_in;
    logic               end_in;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    edge_t [EDGE_COUNT-1:0] e;
  } item_t;

  typedef struct packed {
    logic               start_in;
    logic               end_in;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] ex;
    logic signed [31:0] ey;
  } pre_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] tn;
    logic [31:0] td;
    logic [31:0] px;
    logic [31:0] py;
    logic [2:0]  src;
  } hit_t;

  // Crossing of the segment with the edge on line a == level.
  function automatic edge_t classify_edge(
    input logic signed [32:0] d,
    input logic signed [31:0] sa,
    input logic signed [33:0] level,
    input logic signed [31:0] sb,
    input logic signed [32:0] db,
    input logic signed [33:0] lo,
    input logic signed [33:0] hi
  );
    logic signed [34:0] a_raw;
    logic signed [34:0] a_sel;
    logic        [32:0] dabs;
    logic        [32:0] mabs;
    edge_t              e;
    a_raw = 35'(level) - 35'(sa);
    a_sel = d[32] ? -a_raw : a_raw;
    dabs  = d[32] ? 33'(-d) : 33'(d);
    mabs  = db[32] ? 33'(-db) : 33'(db);
    e.ok    = (d != 33'sd0) && (hi != lo) && !a_sel[34] &&
              (a_sel[33:0] <= {1'b0, dabs});
    e.a     = a_sel[31:0];
    e.d     = dabs[31:0];
    e.m     = mabs[31:0];
    e.neg   = db[32];
    e.sb    = sb;
    e.lo    = lo;
    e.hi    = hi;
    e.level = level;
    return e;
  endfunction

endpackage

### hw/rtl/srfh_front.sv
// Front end: register the word, form the far edges, classify the top, right, bottom and left edges.
`timescale 1ns / 1ps
module srfh_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_rect_left,
  input  logic signed [31:0]  in_rect_top,
  input  logic        [30:0]  in_rect_width,
  input  logic        [30:0]  in_rect_height,
  input  logic signed [31:0]  in_start_x,
  input  logic signed [31:0]  in_start_y,
  input  logic signed [31:0]  in_end_x,
  input  logic signed [31:0]  in_end_y,
  output logic                push,
  input  logic                q_full,
  output srfh_pkg::item_t     push_item
);
  import srfh_pkg::*;

  logic               f1_v_r;
  logic signed [31:0] l_r, t_r, sx_r, sy_r, ex_r, ey_r;
  logic signed [33:0] r_r, b_r;
  logic signed [32:0] dx_r, dy_r;
  logic               f2_v_r;
  item_t              item_r;
  item_t              item_nxt;
  logic               en1, en2;

  assign en2      = !f2_v_r || !q_full;
  assign en1      = !f1_v_r || en2;
  assign in_stall = !en1;
  assign push     = f2_v_r && !q_full;
  assign push_item = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      if (en1) f1_v_r <= in_valid;
      if (en2) f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      l_r  <= in_rect_left;
      t_r  <= in_rect_top;
      sx_r <= in_start_x;
      sy_r <= in_start_y;
      ex_r <= in_end_x;
      ey_r <= in_end_y;
      r_r  <= 34'(in_rect_left) + $signed({3'b000, in_rect_width});
      b_r  <= 34'(in_rect_top) + $signed({3'b000, in_rect_height});
      dx_r <= 33'(in_end_x) - 33'(in_start_x);
      dy_r <= 33'(in_end_y) - 33'(in_start_y);
    end
    if (en2) item_r <= item_nxt;
  end

  always_comb begin
    item_nxt.start_in = (sx_r >= l_r) && (34'(sx_r) < r_r) &&
                        (sy_r >= t_r) && (34'(sy_r) < b_r);
    item_nxt.end_in   = (ex_r >= l_r) && (34'(ex_r) < r_r) &&
                        (ey_r >= t_r) && (34'(ey_r) < b_r);
    item_nxt.sx = sx_r;
    item_nxt.sy = sy_r;
    item_nxt.ex = ex_r;
    item_nxt.ey = ey_r;
    // edge order: top, right, bottom, left
    item_nxt.e[0] = classify_edge(dy_r, sy_r, 34'(t_r), sx_r, dx_r, 34'(l_r), r_r);
    item_nxt.e[1] = classify_edge(dx_r, sx_r, r_r, sy_r, dy_r, 34'(t_r), b_r);
    item_nxt.e[2] = classify_edge(dy_r, sy_r, b_r, sx_r, dx_r, 34'(l_r), r_r);
    item_nxt.e[3] = classify_edge(dx_r, sx_r, 34'(l_r), sy_r, dy_r, 34'(t_r), b_r);
  end

endmodule

### hw/rtl/srfh_queue.sv
// Small FIFO between the front end and the back end.
`timescale 1ns / 1ps
module srfh_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  srfh_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output srfh_pkg::item_t head
);
  import srfh_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == FULL_COUNT);
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

endmodule

### hw/rtl/srfh_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module srfh_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quo,
  output logic [31:0] rem
);
  import srfh_pkg::*;

  logic [31:0] rem_r [DIV_STEPS];
  logic [31:0] low_r [DIV_STEPS];
  logic [31:0] quo_r [DIV_STEPS];
  logic [31:0] div_r [DIV_STEPS];

  genvar k;
  generate
    for (k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [31:0] rem_in, low_in, quo_in, div_in;
      logic [32:0] trial;
      logic        take;
      if (k == 0) begin : g_first
        assign rem_in = dividend[63:32];
        assign low_in = dividend[31:0];
        assign quo_in = '0;
        assign div_in = divisor;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign low_in = low_r[k-1];
        assign quo_in = quo_r[k-1];
        assign div_in = div_r[k-1];
      end
      assign trial = {rem_in, low_in[31]};
      assign take  = (trial >= {1'b0, div_in});
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? 32'(trial - {1'b0, div_in}) : trial[31:0];
          low_r[k] <= {low_in[30:0], 1'b0};
          quo_r[k] <= {quo_in[30:0], take};
          div_r[k] <= div_in;
        end
      end
    end
  endgenerate

  assign quo = quo_r[DIV_STEPS-1];
  assign rem = rem_r[DIV_STEPS-1];

endmodule

### hw/rtl/srfh_back.sv
// Back end: multiply, divide, resolve crossings, pick start inside, end inside or the earliest hit.
`timescale 1ns / 1ps
module srfh_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  srfh_pkg::item_t    q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic        [2:0]  out_hit_source
);
  import srfh_pkg::*;

  logic        en;
  logic        v0_r, v1_r, vc1_r, vc2_r, vc3_r, vc4_r, out_v_r;
  logic        vd_r [DIV_STEPS];
  item_t       item0_r, item1_r;
  item_t       side_r [DIV_STEPS];
  logic [63:0] prod_r [EDGE_COUNT];
  logic [31:0] quo [EDGE_COUNT];
  logic [31:0] rem [EDGE_COUNT];
  hit_t        h1_r [EDGE_COUNT];
  hit_t        h2_r [EDGE_COUNT];
  logic [63:0] pa01_r, pb01_r, pa23_r, pb23_r, pa_r, pb_r;
  hit_t        w01_r, w23_r, w01b_r, w23b_r;
  pre_t        pre1_r, pre2_r, pre3_r, pre4_r;
  hit_t        w_fin;
  logic        hit_nxt;
  logic [31:0] px_nxt, py_nxt;
  logic [2:0]  src_nxt;
  logic        hit_r;
  logic [31:0] px_r, py_r;
  logic [2:0]  src_r;

  assign en  = !out_v_r || !out_stall;
  assign pop = en && !q_empty;

  function automatic hit_t resolve(input edge_t e, input logic [31:0] q,
                                   input logic [31:0] r, input logic vert,
                                   input logic [2:0] src);
    logic signed [34:0] qs, inc, fl, ce, tr, sbx, pb;
    hit_t h;
    qs  = $signed({3'b000, q});
    inc = (r != 32'd0) ? 35'sd1 : 35'sd0;
    sbx = 35'(e.sb);
    if (!e.neg) begin
      fl = qs;
      ce = qs + inc;
      tr = fl;
    end else begin
      ce = -qs;
      fl = ce - inc;
      tr = ce;
    end
    pb    = sbx + tr;
    h.ok  = e.ok && (sbx + fl >= 35'(e.lo)) && (sbx + ce <= 35'(e.hi));
    h.tn  = e.a;
    h.td  = e.d;
    h.px  = vert ? e.level[31:0] : pb[31:0];
    h.py  = vert ? pb[31:0] : e.level[31:0];
    h.src = src;
    return h;
  endfunction

  // take the later edge if it hits and the earlier misses, or on a strictly earlier crossing
  function automatic hit_t pick(input hit_t lo_h, input hit_t hi_h,
                                input logic [63:0] p_hi, input logic [63:0] p_lo);
    logic take;
    take = hi_h.ok && (!lo_h.ok || (p_hi < p_lo));
    return take ? hi_h : lo_h;
  endfunction

  function automatic pre_t to_pre(input item_t it);
    pre_t p;
    p.start_in = it.start_in;
    p.end_in   = it.end_in;
    p.sx = it.sx;
    p.sy = it.sy;
    p.ex = it.ex;
    p.ey = it.ey;
    return p;
  endfunction

  genvar g;
  generate
    for (g = 0; g < EDGE_COUNT; g++) begin : g_edge
      srfh_div u_div (
        .clk      (clk),
        .en       (en),
        .dividend (prod_r[g]),
        .divisor  (item1_r.e[g].d),
        .quo      (quo[g]),
        .rem      (rem[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r    <= 1'b0;
      v1_r    <= 1'b0;
      vc1_r   <= 1'b0;
      vc2_r   <= 1'b0;
      vc3_r   <= 1'b0;
      vc4_r   <= 1'b0;
      out_v_r <= 1'b0;
      for (int k = 0; k < DIV_STEPS; k++) vd_r[k] <= 1'b0;
    end else if (en) begin
      v0_r    <= !q_empty;
      v1_r    <= v0_r;
      vd_r[0] <= v1_r;
      for (int k = 1; k < DIV_STEPS; k++) vd_r[k] <= vd_r[k-1];
      vc1_r   <= vd_r[DIV_STEPS-1];
      vc2_r   <= vc1_r;
      vc3_r   <= vc2_r;
      vc4_r   <= vc3_r;
      out_v_r <= vc4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item0_r <= q_head;
      item1_r <= item0_r;
      for (int i = 0; i < EDGE_COUNT; i++)
        prod_r[i] <= 64'(item0_r.e[i].a) * 64'(item0_r.e[i].m);
      side_r[0] <= item1_r;
      for (int k = 1; k < DIV_STEPS; k++) side_r[k] <= side_r[k-1];
      for (int i = 0; i < EDGE_COUNT; i++)
        h1_r[i] <= resolve(side_r[DIV_STEPS-1].e[i], quo[i], rem[i], i[0],
                           SRC_EDGE0 + 3'(i));
      pre1_r <= to_pre(side_r[DIV_STEPS-1]);
      for (int i = 0; i < EDGE_COUNT; i++) h2_r[i] <= h1_r[i];
      pa01_r <= 64'(h1_r[1].tn) * 64'(h1_r[0].td);
      pb01_r <= 64'(h1_r[0].tn) * 64'(h1_r[1].td);
      pa23_r <= 64'(h1_r[3].tn) * 64'(h1_r[2].td);
      pb23_r <= 64'(h1_r[2].tn) * 64'(h1_r[3].td);
      pre2_r <= pre1_r;
      w01_r  <= pick(h2_r[0], h2_r[1], pa01_r, pb01_r);
      w23_r  <= pick(h2_r[2], h2_r[3], pa23_r, pb23_r);
      pre3_r <= pre2_r;
      w01b_r <= w01_r;
      w23b_r <= w23_r;
      pa_r   <= 64'(w23_r.tn) * 64'(w01_r.td);
      pb_r   <= 64'(w01_r.tn) * 64'(w23_r.td);
      pre4_r <= pre3_r;
      hit_r  <= hit_nxt;
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      src_r  <= src_nxt;
    end
  end

  always_comb begin
    w_fin = pick(w01b_r, w23b_r, pa_r, pb_r);
    if (pre4_r.start_in) begin
      hit_nxt = 1'b1;
      px_nxt  = pre4_r.sx;
      py_nxt  = pre4_r.sy;
      src_nxt = SRC_START;
    end else if (pre4_r.end_in) begin
      hit_nxt = 1'b1;
      px_nxt  = pre4_r.ex;
      py_nxt  = pre4_r.ey;
      src_nxt = SRC_END;
    end else if (w_fin.ok) begin
      hit_nxt = 1'b1;
      px_nxt  = w_fin.px;
      py_nxt  = w_fin.py;
      src_nxt = w_fin.src;
    end else begin
      hit_nxt = 1'b0;
      px_nxt  = '0;
      py_nxt  = '0;
      src_nxt = SRC_START;
    end
  end

  assign out_valid      = out_v_r;
  assign out_hit        = hit_r;
  assign out_point_x    = px_r;
  assign out_point_y    = py_r;
  assign out_hit_source = src_r;

endmodule

### hw/rtl/segment_rect_first_hit.sv
// Top level: first point where a segment meets an axis-aligned rectangle.
//
// Input channel (in_valid / in_stall): one word carries a rectangle (corner,
// width, height), segment (start, end): signed fixed point, sizes unsigned.
// Result channel (out_valid / out_stall): one word per input word, in order:
// hit flag, chosen point and its source (start inside, end inside, or the
// edge index plus two). With no hit the point and source read as zero.
// Throughput: one word per cycle while out_stall is low. Each edge has its
// own 32x32 multiplier and a 32-stage divider, one quotient bit per stage.
// From acceptance to out_valid: two front stages, the queue, its head
// register, the product stage, 32 divider stages, four stages of crossing
// resolve and earliest-hit selection, then the output register.
// Reset (rst_n low, synchronous) empties the pipeline and the queue.
// When the receiver stalls a valid output word, the back end holds in place and
// the word stays put; the front end keeps taking words until the queue fills,
// and only then raises in_stall.
`timescale 1ns / 1ps
module segment_rect_first_hit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_rect_left,
  input  logic signed [31:0] in_rect_top,
  input  logic        [30:0] in_rect_width,
  input  logic        [30:0] in_rect_height,
  input  logic signed [31:0] in_start_x,
  input  logic signed [31:0] in_start_y,
  input  logic signed [31:0] in_end_x,
  input  logic signed [31:0] in_end_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic        [2:0]  out_hit_source
);
  import srfh_pkg::*;

  logic  push, q_full, pop, q_empty;
  item_t push_item, q_head;

  // accept, form far edges, classify each edge
  srfh_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rect_left   (in_rect_left),
    .in_rect_top    (in_rect_top),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .push           (push),
    .q_full         (q_full),
    .push_item      (push_item)
  );

  // decouple the front from output stalls
  srfh_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // crossings, ranking and the output register
  srfh_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_hit_source (out_hit_source)
  );

  // a miss carries a zero point and source
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |->
      (out_point_x == 32'sd0 && out_point_y == 32'sd0 && out_hit_source == SRC_START))
    else $error("miss word with nonzero payload");

  // only six source codes exist
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit_source != 3'd6 && out_hit_source != 3'd7))
    else $error("hit source out of range");

  // nothing leaves the block right after reset
  assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("output valid after reset");

  // a full queue that is not popped does not go empty
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_full && !pop) |=> !q_empty)
    else $error("queue lost its contents");

endmodule
